// File: sv/atb_pkg.sv
// Shared types, register codes and sizing constants for the ATA taskfile command builder.
package atb_pkg;

   localparam int ATB_QUEUE_DEPTH = 2;

   localparam int BLK_W      = 48;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 3;
   localparam int MODE_W     = 2;
   localparam int SPT_W      = 8;
   localparam int HPC_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int STEP_W     = 4;

   // radix-16 long division: four quotient bits per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = BLK_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [ADDR_W-1:0] reg_addr_type;

   localparam reg_addr_type REG_FEATURES = 3'd1;
   localparam reg_addr_type REG_COUNT    = 3'd2;
   localparam reg_addr_type REG_SECTOR   = 3'd3;
   localparam reg_addr_type REG_CYL_LO   = 3'd4;
   localparam reg_addr_type REG_CYL_HI   = 3'd5;
   localparam reg_addr_type REG_SELECT   = 3'd6;
   localparam reg_addr_type REG_COMMAND  = 3'd7;

   localparam logic [MODE_W-1:0] MODE_CHS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LBA28 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LBA48 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HPC       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE     = 3'd3;

   localparam logic REQ_READ     = 1'b0;
   localparam logic REQ_IDENTIFY = 1'b1;

   localparam logic [BYTE_W-1:0] SEL_FIXED    = 8'hA0;
   localparam logic [BYTE_W-1:0] SEL_LBA      = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_IDENTIFY = 8'hEC;
   localparam logic [BYTE_W-1:0] READ_COUNT   = 8'h01;

   localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
   localparam logic [HPC_W-1:0] HPC_RESET = 5'd16;

   localparam logic [STEP_W-1:0] SHORT_LAST = 4'd6;
   localparam logic [STEP_W-1:0] LONG_LAST  = 4'd11;

   typedef struct packed {
      logic [MODE_W-1:0] addr_mode;
      logic [SPT_W-1:0]  sectors_per_track;
      logic [HPC_W-1:0]  heads_per_cylinder;
      logic              drive_unit;
   } atb_cfg_type;

   // short form: addr_bytes[7:0] sector, [15:8] cyl_lo, [23:16] cyl_hi
   // long form:  addr_bytes is the full 48-bit LBA
   typedef struct packed {
      logic              long_form;
      logic [BYTE_W-1:0] sel_byte;
      logic [BYTE_W-1:0] cmd_byte;
      logic [BYTE_W-1:0] count_byte;
      logic [BLK_W-1:0]  addr_bytes;
   } atb_entry_type;

   typedef struct packed {
      reg_addr_type      reg_addr;
      logic [BYTE_W-1:0] reg_data;
      logic              last_write;
   } atb_write_type;

   typedef struct packed {
      logic              done;
      logic [BLK_W-1:0]  quotient;
      logic [BYTE_W-1:0] remainder;
   } atb_div_rsp_type;

endpackage

// File: sv/atb_div.sv
// Iterative 48-by-8 unsigned divider, four quotient bits per cycle.
module atb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [atb_pkg::BLK_W-1:0]     dividend,
   input  logic [atb_pkg::BYTE_W-1:0]    divisor,
   output atb_pkg::atb_div_rsp_type      rsp
);
   import atb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLK_W-1:0]     quo_ff, quo_in;
   logic [BYTE_W-1:0]    rem_ff, rem_in;
   logic [BYTE_W-1:0]    dsr_ff, dsr_in;

   logic [BLK_W-1:0]     quo_step;
   logic [BYTE_W-1:0]    rem_step;

   // quo_ff shifts dividend bits out the top and quotient bits in the bottom
   always_comb begin
      logic [BYTE_W:0] trial;
      logic            q_bit;
      quo_step = quo_ff;
      rem_step = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {rem_step, quo_step[BLK_W-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            q_bit = 1'b1;
         end else begin
            q_bit = 1'b0;
         end
         rem_step = trial[BYTE_W-1:0];
         quo_step = {quo_step[BLK_W-2:0], q_bit};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished division");

endmodule

// File: sv/atb_front.sv
// Front end: accepts requests, classifies them and builds queue entries (CHS via divider).
module atb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  atb_pkg::atb_cfg_type          cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [atb_pkg::BLK_W-1:0]     req_block_number,
   input  logic [atb_pkg::BYTE_W-1:0]    req_command_code,
   output logic                          q_wr_valid,
   input  logic                          q_wr_ready,
   output atb_pkg::atb_entry_type        q_wr_data
);
   import atb_pkg::*;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_DIV_TRACK = 2'd1;
   localparam logic [1:0] ST_DIV_HEAD  = 2'd2;
   localparam logic [1:0] ST_PUSH      = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] sector_ff, sector_in;

   logic              is_chs;
   logic              accept;
   logic [SPT_W-1:0]  spt_eff;
   logic [HPC_W-1:0]  hpc_eff;
   logic [BYTE_W-1:0] drv_bits;

   logic              div_start;
   logic [BLK_W-1:0]  div_dividend;
   logic [BYTE_W-1:0] div_divisor;
   atb_div_rsp_type   div_rsp;

   atb_entry_type     direct_entry;
   atb_entry_type     chs_entry;

   atb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .rsp      (div_rsp)
   );

   assign is_chs   = (req_type == REQ_READ) && (cfg.addr_mode == MODE_CHS);
   assign spt_eff  = (cfg.sectors_per_track == '0) ? SPT_W'(1) : cfg.sectors_per_track;
   assign hpc_eff  = (cfg.heads_per_cylinder == '0) ? HPC_W'(1) : cfg.heads_per_cylinder;
   assign drv_bits = {3'b000, cfg.drive_unit, 4'b0000};

   assign req_ready = (state_ff == ST_IDLE) && q_wr_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      div_start    = 1'b0;
      div_dividend = req_block_number;
      div_divisor  = spt_eff;
      if (state_ff == ST_IDLE && accept && is_chs) begin
         div_start = 1'b1;
      end else if (state_ff == ST_DIV_TRACK && div_rsp.done) begin
         div_start    = 1'b1;
         div_dividend = div_rsp.quotient;
         div_divisor  = {{(BYTE_W-HPC_W){1'b0}}, hpc_eff};
      end
   end

   // mode 3 falls into the lba48 arm along with mode 2
   always_comb begin
      if (req_type == REQ_IDENTIFY) begin
         direct_entry.long_form  = 1'b0;
         direct_entry.sel_byte   = SEL_FIXED | drv_bits;
         direct_entry.cmd_byte   = CMD_IDENTIFY;
         direct_entry.count_byte = '0;
         direct_entry.addr_bytes = '0;
      end else if (cfg.addr_mode[1]) begin
         direct_entry.long_form  = 1'b1;
         direct_entry.sel_byte   = SEL_LBA | drv_bits;
         direct_entry.cmd_byte   = req_command_code;
         direct_entry.count_byte = READ_COUNT;
         direct_entry.addr_bytes = req_block_number;
      end else begin
         direct_entry.long_form  = 1'b0;
         direct_entry.sel_byte   = SEL_FIXED | SEL_LBA | drv_bits
                                   | {4'b0000, req_block_number[27:24]};
         direct_entry.cmd_byte   = req_command_code;
         direct_entry.count_byte = READ_COUNT;
         direct_entry.addr_bytes = {24'd0, req_block_number[23:0]};
      end
   end

   // divider holds cylinder quotient and head remainder until the next start
   always_comb begin
      chs_entry.long_form  = 1'b0;
      chs_entry.sel_byte   = SEL_FIXED | drv_bits | {4'b0000, div_rsp.remainder[3:0]};
      chs_entry.cmd_byte   = cmd_ff;
      chs_entry.count_byte = READ_COUNT;
      chs_entry.addr_bytes = {24'd0, div_rsp.quotient[15:0], sector_ff};
   end

   assign q_wr_valid = ((state_ff == ST_IDLE) && req_valid && !is_chs) || (state_ff == ST_PUSH);
   assign q_wr_data  = (state_ff == ST_PUSH) ? chs_entry : direct_entry;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      sector_in = sector_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_chs) begin
               state_in = ST_DIV_TRACK;
               cmd_in   = req_command_code;
            end
         end
         ST_DIV_TRACK: begin
            if (div_rsp.done) begin
               state_in  = ST_DIV_HEAD;
               sector_in = div_rsp.remainder + 8'd1;
            end
         end
         ST_DIV_HEAD: begin
            if (div_rsp.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (q_wr_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sector_ff <= sector_in;
   end

   a_no_push_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_TRACK || state_ff == ST_DIV_HEAD) |-> !q_wr_valid && !req_ready)
      else $error("front pushed or accepted during CHS translation");

endmodule

// File: sv/atb_fifo.sv
// Short entry queue between the front end and the write sequencer.
module atb_fifo #(
   parameter int DEPTH = atb_pkg::ATB_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   output logic                   wr_ready,
   input  atb_pkg::atb_entry_type wr_data,
   output logic                   rd_valid,
   input  logic                   rd_pop,
   output atb_pkg::atb_entry_type rd_data
);
   import atb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   atb_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;
   logic             pop;

   assign wr_ready = (cnt_ff != CNT_W'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rd_pop |-> rd_valid)
      else $error("sequencer popped an empty queue");

endmodule

// File: sv/atb_back.sv
// Write sequencer: expands each queue entry into taskfile register writes.
module atb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_valid,
   output logic                          rd_pop,
   input  atb_pkg::atb_entry_type        rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [atb_pkg::ADDR_W-1:0]    rsp_reg_addr,
   output logic [atb_pkg::BYTE_W-1:0]    rsp_reg_data,
   output logic                          rsp_last_write
);
   import atb_pkg::*;

   function automatic atb_write_type write_at(atb_entry_type e, logic [STEP_W-1:0] step);
      atb_write_type w;
      w.reg_addr   = REG_FEATURES;
      w.reg_data   = '0;
      w.last_write = 1'b0;
      if (e.long_form) begin
         // select, high-order (previous) bytes, low-order (current) bytes, command
         unique case (step)
            4'd0:  begin w.reg_addr = REG_SELECT; w.reg_data = e.sel_byte; end
            4'd1:  w.reg_addr = REG_FEATURES;
            4'd2:  w.reg_addr = REG_COUNT;
            4'd3:  begin w.reg_addr = REG_CYL_HI; w.reg_data = e.addr_bytes[47:40]; end
            4'd4:  begin w.reg_addr = REG_CYL_LO; w.reg_data = e.addr_bytes[39:32]; end
            4'd5:  begin w.reg_addr = REG_SECTOR; w.reg_data = e.addr_bytes[31:24]; end
            4'd6:  w.reg_addr = REG_FEATURES;
            4'd7:  begin w.reg_addr = REG_COUNT;  w.reg_data = e.count_byte; end
            4'd8:  begin w.reg_addr = REG_CYL_HI; w.reg_data = e.addr_bytes[23:16]; end
            4'd9:  begin w.reg_addr = REG_CYL_LO; w.reg_data = e.addr_bytes[15:8]; end
            4'd10: begin w.reg_addr = REG_SECTOR; w.reg_data = e.addr_bytes[7:0]; end
            default: begin
               w.reg_addr   = REG_COMMAND;
               w.reg_data   = e.cmd_byte;
               w.last_write = 1'b1;
            end
         endcase
      end else begin
         unique case (step)
            4'd0: w.reg_addr = REG_FEATURES;
            4'd1: begin w.reg_addr = REG_COUNT;  w.reg_data = e.count_byte; end
            4'd2: begin w.reg_addr = REG_SECTOR; w.reg_data = e.addr_bytes[7:0]; end
            4'd3: begin w.reg_addr = REG_CYL_LO; w.reg_data = e.addr_bytes[15:8]; end
            4'd4: begin w.reg_addr = REG_CYL_HI; w.reg_data = e.addr_bytes[23:16]; end
            4'd5: begin w.reg_addr = REG_SELECT; w.reg_data = e.sel_byte; end
            default: begin
               w.reg_addr   = REG_COMMAND;
               w.reg_data   = e.cmd_byte;
               w.last_write = 1'b1;
            end
         endcase
      end
      return w;
   endfunction

   logic                rsp_valid_ff, rsp_valid_in;
   atb_write_type       rsp_ff, rsp_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                advance;
   atb_write_type       cur;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign cur     = write_at(rd_data, step_ff);
   assign rd_pop  = advance && rd_valid && cur.last_write;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      step_in      = step_ff;
      if (advance) begin
         rsp_valid_in = rd_valid;
         if (rd_valid) begin
            rsp_in  = cur;
            step_in = cur.last_write ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_addr   = rsp_ff.reg_addr;
   assign rsp_reg_data   = rsp_ff.reg_data;
   assign rsp_last_write = rsp_ff.last_write;

   a_last_is_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_write |-> rsp_ff.reg_addr == REG_COMMAND)
      else $error("sequence ended on a non-command write");

   a_mid_sequence_entry: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0 |-> rd_valid)
      else $error("entry left the queue in mid-sequence");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= LONG_LAST && (rd_data.long_form || !rd_valid || step_ff <= SHORT_LAST))
      else $error("write step beyond the sequence length");

endmodule

// File: sv/ata_taskfile_command_builder_top.sv
// Top level of the ATA taskfile command builder: config registers and front/queue/back.
//
// Requests (req_*) carry a read or identify. Each one is expanded into the ordered
// taskfile writes that issue it, delivered on rsp_* one per transaction; rsp_last_write
// marks the command-register write that ends a sequence. Configuration (csr_*) is
// always ready; indexes 0..3 select addr_mode, sectors_per_track, heads_per_cylinder
// and drive_unit, other indexes are dropped. Write it only while the block is idle.
// Lba28, lba48 and identify requests are classified and queued in the accept cycle;
// the sequencer then takes the entry from the queue and registers each write on rsp_*,
// one write per cycle unless a low rsp_ready holds the output register, 12 writes for
// lba48 and 7 otherwise. CHS requests go through a shared 4-bit-per-cycle divider twice
// (block by sectors per track, track by heads) before its entry is queued; the front
// takes no new request meanwhile. Sustained throughput is bound by the write sequencer
// for lba28, lba48 and identify items and by the divider for CHS items.
// A queue of QUEUE_DEPTH entries sits between front and sequencer, so requests are
// taken while earlier writes are still draining. When rsp_ready is low the output
// register holds and the queue fills, then req_ready drops. Reset empties the queue,
// drops rsp_valid and loads the config defaults (lba28, 63 sectors, 16 heads, master).
module ata_taskfile_command_builder_top #(
   parameter int QUEUE_DEPTH = atb_pkg::ATB_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [atb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [atb_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [atb_pkg::BLK_W-1:0]         req_block_number,
   input  logic [atb_pkg::BYTE_W-1:0]        req_command_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [atb_pkg::ADDR_W-1:0]        rsp_reg_addr,
   output logic [atb_pkg::BYTE_W-1:0]        rsp_reg_data,
   output logic                              rsp_last_write
);
   import atb_pkg::*;

   logic [MODE_W-1:0] addr_mode_ff, addr_mode_in;
   logic [SPT_W-1:0]  spt_ff, spt_in;
   logic [HPC_W-1:0]  hpc_ff, hpc_in;
   logic              drive_ff, drive_in;
   logic              csr_write;
   atb_cfg_type       cfg;

   logic              q_wr_valid;
   logic              q_wr_ready;
   atb_entry_type     q_wr_data;
   logic              q_rd_valid;
   logic              q_rd_pop;
   atb_entry_type     q_rd_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      addr_mode_in = addr_mode_ff;
      spt_in       = spt_ff;
      hpc_in       = hpc_ff;
      drive_in     = drive_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ADDR_MODE: addr_mode_in = csr_data[MODE_W-1:0];
            CSR_SPT:       spt_in       = csr_data[SPT_W-1:0];
            CSR_HPC:       hpc_in       = csr_data[HPC_W-1:0];
            CSR_DRIVE:     drive_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_mode_ff <= MODE_LBA28;
         spt_ff       <= SPT_RESET;
         hpc_ff       <= HPC_RESET;
         drive_ff     <= 1'b0;
      end else begin
         addr_mode_ff <= addr_mode_in;
         spt_ff       <= spt_in;
         hpc_ff       <= hpc_in;
         drive_ff     <= drive_in;
      end
   end

   assign cfg.addr_mode          = addr_mode_ff;
   assign cfg.sectors_per_track  = spt_ff;
   assign cfg.heads_per_cylinder = hpc_ff;
   assign cfg.drive_unit         = drive_ff;

   atb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_block_number (req_block_number),
      .req_command_code (req_command_code),
      .q_wr_valid       (q_wr_valid),
      .q_wr_ready       (q_wr_ready),
      .q_wr_data        (q_wr_data)
   );

   atb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_pop   (q_rd_pop),
      .rd_data  (q_rd_data)
   );

   atb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .rd_valid       (q_rd_valid),
      .rd_pop         (q_rd_pop),
      .rd_data        (q_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_addr   (rsp_reg_addr),
      .rsp_reg_data   (rsp_reg_data),
      .rsp_last_write (rsp_last_write)
   );

endmodule
